// File: rtl/btnrpt_pkg.sv
`default_nettype none

package btnrpt_pkg;

  localparam int unsigned BTN_W  = 16;
  localparam int unsigned HOLD_W = 9;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 2;

  localparam logic [BTN_W-1:0]  REPEATABLE_MASK  = 16'hf00c;
  localparam logic [BTN_W-1:0]  PRIMARY_ALT_MASK = 16'ha000;
  localparam logic [BTN_W-1:0]  PRIMARY_MASK     = 16'hf000;
  localparam logic [BTN_W-1:0]  SECOND_ALT_MASK  = 16'h500c;
  localparam logic [BTN_W-1:0]  SECOND_MASK      = 16'h000c;
  localparam int unsigned       ALT_SELECT_IDX   = 7;
  localparam logic [HOLD_W-1:0] HOLD_SATURATE    = 9'd256;

  localparam logic [IDX_W-1:0] REG_FIRST_DELAY      = 2'd0;
  localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD    = 2'd1;
  localparam logic [IDX_W-1:0] REG_SECONDARY_PERIOD = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] first_delay;
    logic [CFG_W-1:0] repeat_period;
    logic [CFG_W-1:0] secondary_period;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0]  held_buttons;
    logic [HOLD_W-1:0] hold_count;
    logic [CNT_W-1:0]  primary_count;
    logic [CNT_W-1:0]  secondary_count;
  } rpt_state_t;

endpackage

`default_nettype wire

// File: rtl/button_edge_and_auto_repeat.sv
`default_nettype none

// Button edge detector with typematic auto-repeat. Each input transfer carries one
// 16-bit pad sample (in_tdata) and a suppress flag (in_tuser) that clears the repeat
// counters; each produces exactly one output transfer with the press or repeat
// events for that tick. The block sustains one transfer per clock: a sample sits in
// an input register, the counter and mask logic updates the held state and loads the
// output register, and the only stall comes from out_tready. Load the three tick
// counts through the cfg port while no transfer is in flight.
module button_edge_and_auto_repeat
  import btnrpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [15:0]      in_tdata,   // [15:0] buttons
  input  wire logic [0:0]       in_tuser,   // [0] suppress
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_tdata,  // [15:0] event_bits
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_t             cfg;
  rpt_state_t       state_r;
  rpt_state_t       state_nxt;
  logic             in_v_r;
  logic [BTN_W-1:0] in_btn_r;
  logic             in_sup_r;
  logic             out_v_r;
  logic [BTN_W-1:0] out_ev_r;
  logic [BTN_W-1:0] ev_nxt;
  logic             advance;

  btnrpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  btnrpt_step u_step (
    .cfg        (cfg),
    .cur_state  (state_r),
    .buttons    (in_btn_r),
    .suppress   (in_sup_r),
    .next_state (state_nxt),
    .event_bits (ev_nxt)
  );

  assign advance    = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || advance;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_btn_r <= in_tdata;
      in_sup_r <= in_tuser[0];
    end
    if (advance) begin
      out_ev_r <= ev_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/btnrpt_cfg.sv
`default_nettype none

module btnrpt_cfg
  import btnrpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_DELAY:      cfg_nxt.first_delay      = cfg_wdata;
        REG_REPEAT_PERIOD:    cfg_nxt.repeat_period    = cfg_wdata;
        REG_SECONDARY_PERIOD: cfg_nxt.secondary_period = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/btnrpt_step.sv
`default_nettype none

module btnrpt_step
  import btnrpt_pkg::*;
(
  input  wire cfg_t             cfg,
  input  wire rpt_state_t       cur_state,
  input  wire logic [BTN_W-1:0] buttons,
  input  wire logic             suppress,
  output rpt_state_t            next_state,
  output logic [BTN_W-1:0]      event_bits
);

  logic              clr;
  logic [HOLD_W-1:0] h0;
  logic [HOLD_W-1:0] h1;
  logic [CNT_W-1:0]  p0;
  logic [CNT_W-1:0]  s0;
  logic [CNT_W-1:0]  p1;
  logic [CNT_W-1:0]  s1;
  logic [BTN_W-1:0]  rep;
  logic [BTN_W-1:0]  pmask;
  logic [BTN_W-1:0]  smask;
  logic [HOLD_W-1:0] init_ext;
  logic              fire_init;
  logic              running;

  always_comb begin
    clr      = (buttons == '0) || suppress;
    h0       = clr ? '0 : cur_state.hold_count;
    p0       = clr ? '0 : cur_state.primary_count;
    s0       = clr ? '0 : cur_state.secondary_count;
    rep      = buttons & REPEATABLE_MASK;
    pmask    = buttons[ALT_SELECT_IDX] ? PRIMARY_ALT_MASK : PRIMARY_MASK;
    smask    = buttons[ALT_SELECT_IDX] ? SECOND_ALT_MASK : SECOND_MASK;
    h1       = (h0 < HOLD_SATURATE) ? h0 + 1'b1 : h0;
    p1       = p0 + 1'b1;
    s1       = s0 + 1'b1;
    init_ext = {1'b0, cfg.first_delay};
    fire_init = (h1 == init_ext);
    running   = (h1 >= init_ext);

    next_state.held_buttons = buttons;
    if ((cur_state.held_buttons != buttons) || (rep == '0)) begin
      event_bits                 = ~cur_state.held_buttons & buttons;
      next_state.hold_count      = '0;
      next_state.primary_count   = p0;
      next_state.secondary_count = s0;
    end else begin
      event_bits                 = fire_init ? rep : '0;
      next_state.hold_count      = h1;
      next_state.primary_count   = '0;
      next_state.secondary_count = '0;
      if (running) begin
        next_state.primary_count   = p1;
        next_state.secondary_count = s1;
        if (p1 >= cfg.repeat_period) begin
          next_state.primary_count = '0;
          event_bits               = buttons & pmask;
        end
        if (s1 >= cfg.secondary_period) begin
          next_state.secondary_count = '0;
          event_bits                 = event_bits | (buttons & smask);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import btnrpt_pkg::*;
;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic             suppress;
  } pad_sample_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;
  logic [0:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  button_edge_and_auto_repeat dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] buttons
    .in_tuser   (in_tuser),   // [0] suppress
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] event_bits
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and register copies
  logic [CFG_W-1:0]  cfg_delay = '0;
  logic [CFG_W-1:0]  cfg_period = '0;
  logic [CFG_W-1:0]  cfg_period2 = '0;
  logic [BTN_W-1:0]  mdl_held = '0;
  logic [HOLD_W-1:0] mdl_hold = '0;
  logic [CNT_W-1:0]  mdl_pri = '0;
  logic [CNT_W-1:0]  mdl_sec = '0;

  pad_sample_t      pending_items[$];
  logic [BTN_W-1:0] event_q[$];
  pad_sample_t      next_sample;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_repeats = 0;
  int unsigned n_saturated = 0;
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  function automatic logic [BTN_W-1:0] predict_events(input logic [BTN_W-1:0] cur,
                                                      input logic sup);
    logic [BTN_W-1:0] prev;
    logic [BTN_W-1:0] rep;
    logic [BTN_W-1:0] ev;
    logic             alt;
    ev = '0;
    if (cur == '0 || sup) begin
      mdl_hold = '0;
      mdl_pri  = '0;
      mdl_sec  = '0;
    end
    prev     = mdl_held;
    mdl_held = cur;
    rep      = cur & REPEATABLE_MASK;
    alt      = cur[ALT_SELECT_IDX];
    if (prev != cur || rep == '0) begin
      ev       = ~prev & cur;
      mdl_hold = '0;
    end else begin
      if (mdl_hold < HOLD_SATURATE) mdl_hold = mdl_hold + 1'b1;
      if (mdl_hold == HOLD_SATURATE) n_saturated++;
      if (mdl_hold == {1'b0, cfg_delay}) ev = rep;
      if (mdl_hold >= {1'b0, cfg_delay}) begin
        mdl_pri = mdl_pri + 1'b1;
        mdl_sec = mdl_sec + 1'b1;
        if (mdl_pri >= cfg_period) begin
          mdl_pri = '0;
          ev = cur & (alt ? PRIMARY_ALT_MASK : PRIMARY_MASK);
        end
        if (mdl_sec >= cfg_period2) begin
          mdl_sec = '0;
          ev = ev | (cur & (alt ? SECOND_ALT_MASK : SECOND_MASK));
        end
      end else begin
        mdl_pri = '0;
        mdl_sec = '0;
      end
      if (ev != '0) n_repeats++;
    end
    return ev;
  endfunction

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        event_q.push_back(predict_events(in_tdata, in_tuser[0]));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_sample = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_sample.buttons;
          in_tuser  <= next_sample.suppress;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: out_tready follows a randomly chosen stall pattern, redrawn when its countdown expires
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (event_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none actual %04h", $time, out_tdata);
        errors++;
      end else begin
        n_checked++;
        if (out_tdata !== event_q[0]) begin
          $display("%0t: event_bits mismatch: expected %04h actual %04h",
                   $time, event_q[0], out_tdata);
          errors++;
        end
        void'(event_q.pop_front());
      end
    end
  end

  task automatic load_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_cfg(input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] per,
                          input logic [CFG_W-1:0] per2);
    load_reg(REG_FIRST_DELAY, dly);
    load_reg(REG_REPEAT_PERIOD, per);
    load_reg(REG_SECONDARY_PERIOD, per2);
    cfg_delay   = dly;
    cfg_period  = per;
    cfg_period2 = per2;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_queued || event_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_run(input logic [BTN_W-1:0] b, input int unsigned len,
                           input bit sup_all, input bit sup_rand);
    pad_sample_t s;
    for (int i = 0; i < len; i++) begin
      s.buttons  = b;
      s.suppress = sup_all || (sup_rand && $urandom_range(0, 15) == 0);
      pending_items.push_back(s);
      n_queued++;
    end
  endtask

  function automatic logic [BTN_W-1:0] pick_buttons();
    logic [BTN_W-1:0] b;
    b = BTN_W'($urandom);
    case ($urandom_range(0, 9))
      0:       b = '0;
      1, 2:    b = b & ~REPEATABLE_MASK;
      3:       ;
      default: if ((b & REPEATABLE_MASK) == '0) b[12] = 1'b1;
    endcase
    return b;
  endfunction

  task automatic queue_random_phase(input int unsigned target);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    while (cnt < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = 1;
        3:       len = $urandom_range(30, 60);
        default: len = $urandom_range(2, 14);
      endcase
      queue_run(pick_buttons(), len, 1'b0, 1'b1);
      cnt += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: every held tick of a repeatable button repeats
    queue_run(16'h0000, 1, 1'b0, 1'b0);
    queue_run(16'hffff, 3, 1'b0, 1'b0);
    queue_run(16'hff7f, 2, 1'b0, 1'b0);
    queue_run(16'h0f73, 2, 1'b0, 1'b0);
    queue_run(16'h0000, 1, 1'b0, 1'b0);
    queue_run(16'h8000, 3, 1'b1, 1'b0);
    queue_run(16'h0004, 3, 1'b0, 1'b0);
    queue_run(16'h0001, 1, 1'b0, 1'b0);
    queue_run(16'hffff, 2, 1'b1, 1'b0);
    queue_run(16'h0000, 2, 1'b0, 1'b0);
    wait_idle();

    // long holds run the hold counter into saturation
    load_cfg(8'd255, 8'd255, 8'd255);
    queue_run(16'hf08c, 260, 1'b0, 1'b0);
    queue_random_phase(85);
    wait_idle();

    load_cfg(8'd0, 8'd0, 8'd0);
    queue_random_phase(85);
    wait_idle();

    load_cfg(8'd1, 8'd1, 8'd1);
    queue_random_phase(85);
    wait_idle();

    load_cfg(8'd3, 8'd2, 8'd5);
    queue_run(16'h900c, 260, 1'b0, 1'b0);
    queue_random_phase(85);
    wait_idle();

    load_cfg(8'd0, 8'd255, 8'd1);
    queue_random_phase(85);
    wait_idle();

    load_cfg(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
             CFG_W'($urandom_range(0, 255)));
    queue_random_phase(85);
    wait_idle();

    load_cfg(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)),
             CFG_W'($urandom_range(0, 8)));
    queue_random_phase(85);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("Ran %0d pad samples across 8 register settings, %0d results checked.",
             n_accepted, n_checked);
    $display("Held-sample events: %0d, ticks at hold saturation: %0d.",
             n_repeats, n_saturated);
    if (errors == 0 && event_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", event_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: button_edge_and_auto_repeat.f
rtl/btnrpt_pkg.sv
rtl/btnrpt_cfg.sv
rtl/btnrpt_step.sv
rtl/button_edge_and_auto_repeat.sv
verif/tb_top.sv
